### rtl/core/ole_pkg.sv
package ole_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_INS_AFTER  = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_BACK   = 3'd4,
        OP_DEL_MATCH  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SEL_HOLD,
        SEL_LEFT,
        SEL_RIGHT,
        SEL_LOAD
    } cell_sel_t;

    typedef struct packed {
        logic      capture;
        logic      live;
        cell_sel_t sel;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_APPLY
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] match_key;
    } in_item_t;

    typedef struct packed {
        status_t          status;
        logic [CNT_W-1:0] length;
    } out_item_t;

endpackage

### rtl/core/ole_cell.sv
module ole_cell import ole_pkg::*; (
    input  logic                     aclk,
    input  cell_ctl_t                ctl,
    input  logic signed [DATA_W-1:0] key,
    input  logic signed [DATA_W-1:0] left_data,
    input  logic signed [DATA_W-1:0] right_data,
    input  logic signed [DATA_W-1:0] load_data,
    input  logic                     found_in,
    output logic signed [DATA_W-1:0] data,
    output logic                     found_out,
    output logic                     hit
);

    logic signed [DATA_W-1:0] data_reg, data_next;
    logic                     match_reg, match_next;

    always_comb begin
        match_next = ctl.capture ? (ctl.live && (data_reg == key)) : match_reg;
        unique case (ctl.sel)
            SEL_HOLD:  data_next = data_reg;
            SEL_LEFT:  data_next = left_data;
            SEL_RIGHT: data_next = right_data;
            SEL_LOAD:  data_next = load_data;
            default:   data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg  <= data_next;
        match_reg <= match_next;
    end

    assign data      = data_reg;
    assign found_out = found_in | match_reg;
    assign hit       = match_reg & ~found_in;

endmodule

### rtl/core/ordered_list_engine_top.sv
// channel   ports                       direction  carries
// input     s_valid s_ready s_data      in         operation, value, match_key
// result    m_valid m_ready m_data      out        status, length
//
// each transaction steps through accept, search and apply; a new one is taken only after apply
// search compares the key in every cell at once, the first-match flag ripples down the row
// apply shifts the affected cells by one place (push back loads the tail cell) and writes the result register
// a stalled result holds apply until the result register frees up
// aresetn (synchronous, active low) empties the list and drops m_valid
module ordered_list_engine_top import ole_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    state_t           state_reg, state_next;
    in_item_t         cmd_reg, cmd_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg, m_data_next;

    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    cell_ctl_t                cell_ctl  [CAPACITY];
    logic [CAPACITY-1:0]      found_out;
    logic [CAPACITY-1:0]      found_in;
    logic [CAPACITY-1:0]      hit;
    logic [CAPACITY-1:0]      hit_prev;

    logic out_free;
    logic full;
    logic empty;
    logic any_hit;
    logic apply;

    assign out_free = !m_valid_reg || m_ready;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign any_hit  = found_out[CAPACITY-1];
    assign apply    = (state_reg == S_APPLY) && out_free;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [DATA_W-1:0] left_d;
        logic signed [DATA_W-1:0] right_d;

        if (i == 0) begin : g_head
            assign left_d      = cmd_reg.value;
            assign found_in[i] = 1'b0;
            assign hit_prev[i] = 1'b0;
        end else begin : g_body
            assign left_d      = cell_data[i-1];
            assign found_in[i] = found_out[i-1];
            assign hit_prev[i] = hit[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right_d = cell_data[i];
        end else begin : g_inner
            assign right_d = cell_data[i+1];
        end

        ole_cell u_cell (
            .aclk       (aclk),
            .ctl        (cell_ctl[i]),
            .key        (cmd_reg.match_key),
            .left_data  (left_d),
            .right_data (right_d),
            .load_data  (cmd_reg.value),
            .found_in   (found_in[i]),
            .data       (cell_data[i]),
            .found_out  (found_out[i]),
            .hit        (hit[i])
        );
    end

    // per-cell shift control
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_ctl[i].capture = (state_reg == S_SEARCH);
            cell_ctl[i].live    = (CNT_W'(i) < count_reg);
            cell_ctl[i].sel     = SEL_HOLD;
            if (apply) begin
                unique case (op_t'(cmd_reg.operation))
                    OP_PUSH_FRONT: begin
                        if (!full) cell_ctl[i].sel = SEL_LEFT;
                    end
                    OP_PUSH_BACK: begin
                        if (!full && (CNT_W'(i) == count_reg)) cell_ctl[i].sel = SEL_LOAD;
                    end
                    OP_INS_AFTER: begin
                        if (!full) begin
                            if (hit_prev[i]) cell_ctl[i].sel = SEL_LOAD;
                            else if (found_in[i]) cell_ctl[i].sel = SEL_LEFT;
                        end
                    end
                    OP_POP_FRONT: begin
                        if (!empty) cell_ctl[i].sel = SEL_RIGHT;
                    end
                    OP_DEL_MATCH: begin
                        if (!empty && found_out[i]) cell_ctl[i].sel = SEL_RIGHT;
                    end
                    default: cell_ctl[i].sel = SEL_HOLD;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg    <= cmd_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        s_ready      = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next   = s_data;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH: begin
                state_next = S_APPLY;
            end
            S_APPLY: begin
                if (out_free) begin
                    m_data_next.status = ST_DONE;
                    unique case (op_t'(cmd_reg.operation))
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            if (full) m_data_next.status = ST_FULL;
                            else count_next = count_reg + 1'b1;
                        end
                        OP_INS_AFTER: begin
                            if (full) m_data_next.status = ST_FULL;
                            else if (!any_hit) m_data_next.status = ST_NOT_FOUND;
                            else count_next = count_reg + 1'b1;
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (empty) m_data_next.status = ST_EMPTY;
                            else count_next = count_reg - 1'b1;
                        end
                        OP_DEL_MATCH: begin
                            if (empty) m_data_next.status = ST_EMPTY;
                            else if (!any_hit) m_data_next.status = ST_NOT_FOUND;
                            else count_next = count_reg - 1'b1;
                        end
                        default: m_data_next.status = ST_DONE;
                    endcase
                    m_data_next.length = count_next;
                    m_valid_next       = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### rtl/core/ole_checker.sv
module ole_checker import ole_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction taken while one in flight");

    a_empty_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_EMPTY) |-> (m_data.length == '0))
        else $error("empty status with nonzero length");

    a_full_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_FULL) |-> (m_data.length == CNT_W'(CAPACITY)))
        else $error("full status with length below capacity");

endmodule

bind ordered_list_engine_top ole_checker u_ole_checker (.*);

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ole_pkg::*;

    localparam int N_RANDOM       = 850;
    localparam int QUIET_TAIL     = 100;
    localparam int HOLD_CYCLES    = 120;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 40;

    class list_scoreboard;
        logic signed [DATA_W-1:0] cells[$];
        out_item_t                pending_q[$];
        int                       errors;
        int                       commands;
        int                       results;
        int                       status_seen[4];

        function int pending();
            return pending_q.size();
        endfunction

        function int find_key(logic signed [DATA_W-1:0] key);
            foreach (cells[i]) begin
                if (cells[i] === key) begin
                    return i;
                end
            end
            return -1;
        endfunction

        // apply one accepted command to the list and queue its result
        function void note_command(in_item_t cmd);
            out_item_t res;
            int        pos;
            bit        full;
            bit        empty;
            full       = cells.size() >= CAPACITY;
            empty      = cells.size() == 0;
            res.status = ST_DONE;
            case (cmd.operation)
                OP_PUSH_FRONT: begin
                    if (full) res.status = ST_FULL;
                    else cells.push_front(cmd.value);
                end
                OP_PUSH_BACK: begin
                    if (full) res.status = ST_FULL;
                    else cells.push_back(cmd.value);
                end
                OP_INS_AFTER: begin
                    if (full) begin
                        res.status = ST_FULL;
                    end else begin
                        pos = find_key(cmd.match_key);
                        if (pos < 0) res.status = ST_NOT_FOUND;
                        else cells.insert(pos + 1, cmd.value);
                    end
                end
                OP_POP_FRONT: begin
                    if (empty) res.status = ST_EMPTY;
                    else void'(cells.pop_front());
                end
                OP_POP_BACK: begin
                    if (empty) res.status = ST_EMPTY;
                    else void'(cells.pop_back());
                end
                OP_DEL_MATCH: begin
                    if (empty) begin
                        res.status = ST_EMPTY;
                    end else begin
                        pos = find_key(cmd.match_key);
                        if (pos < 0) res.status = ST_NOT_FOUND;
                        else cells.delete(pos);
                    end
                end
                default: begin
                end
            endcase
            res.length = CNT_W'(cells.size());
            status_seen[res.status]++;
            commands++;
            pending_q.push_back(res);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            results++;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t unexpected result: expected none, actual status %0d length %0d",
                             $time, got.status, got.length);
                return;
            end
            want = pending_q.pop_front();
            if (got.status !== want.status) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t status mismatch: expected %0d, actual %0d",
                             $time, want.status, got.status);
            end
            if (got.length !== want.length) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t length mismatch: expected %0d, actual %0d",
                             $time, want.length, got.length);
            end
        endfunction
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    list_scoreboard sb = new();

    int quiet_cycles = 0;
    int hold_left    = 0;
    int stall_left   = 0;
    int idle_pct     = 10;
    bit no_idle      = 1'b0;

    ordered_list_engine_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_data);
            if (s_valid && s_ready) sb.note_command(s_data);
            if ((m_valid && m_ready) || (s_valid && s_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side back-pressure
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (aresetn && !no_idle && $urandom_range(0, 99) < idle_pct) begin
                m_ready    <= 1'b0;
                stall_left = $urandom_range(1, 14) - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        do @(posedge aclk); while (quiet_cycles < WATCHDOG_LIMIT);
        $display("%0t watchdog: no transaction for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, sb.pending());
        $display("ordered_list_engine_top verification failed");
        $finish;
    end

    function automatic in_item_t make_cmd(logic [OP_W-1:0] op, logic [DATA_W-1:0] v,
                                          logic [DATA_W-1:0] k);
        in_item_t c;
        c.operation = op;
        c.value     = v;
        c.match_key = k;
        return c;
    endfunction

    function automatic logic [DATA_W-1:0] random_value();
        logic [DATA_W-1:0] pool[6];
        pool = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0, 32'h1, 32'h2};
        if ($urandom_range(0, 1) == 0) return pool[$urandom_range(0, 5)];
        return $urandom();
    endfunction

    function automatic logic [DATA_W-1:0] random_key();
        if (sb.cells.size() > 0 && $urandom_range(0, 9) < 6)
            return sb.cells[$urandom_range(0, sb.cells.size() - 1)];
        return random_value();
    endfunction

    // growth blocks favor pushes and inserts, shrink blocks favor pops and deletes
    function automatic in_item_t random_command(bit grow);
        logic [OP_W-1:0] op;
        int              r;
        r = $urandom_range(0, 99);
        if (r < 5) op = OP_W'($urandom_range(6, 7));
        else if (grow) begin
            if (r < 30) op = OP_PUSH_FRONT;
            else if (r < 55) op = OP_PUSH_BACK;
            else if (r < 80) op = OP_INS_AFTER;
            else if (r < 86) op = OP_POP_FRONT;
            else if (r < 92) op = OP_POP_BACK;
            else op = OP_DEL_MATCH;
        end else begin
            if (r < 10) op = OP_PUSH_FRONT;
            else if (r < 15) op = OP_PUSH_BACK;
            else if (r < 25) op = OP_INS_AFTER;
            else if (r < 50) op = OP_POP_FRONT;
            else if (r < 70) op = OP_POP_BACK;
            else op = OP_DEL_MATCH;
        end
        return make_cmd(op, random_value(), random_key());
    endfunction

    task automatic send_command(input in_item_t cmd);
        s_valid <= 1'b1;
        s_data  <= cmd;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic sender_gap(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    initial begin
        in_item_t directed[$];
        in_item_t c;
        int       sent;
        int       blk_len;
        bit       grow;
        bit       hold_done;
        bit       pause_done;

        sent       = 0;
        grow       = 1'b0;
        hold_done  = 1'b0;
        pause_done = 1'b0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty list corner cases, extremes, duplicate keys, unused codes
        directed.push_back(make_cmd(OP_POP_FRONT, 32'h0, 32'h0));
        directed.push_back(make_cmd(OP_POP_BACK, 32'h0, 32'h0));
        directed.push_back(make_cmd(OP_DEL_MATCH, 32'h0, 32'h0));
        directed.push_back(make_cmd(OP_INS_AFTER, 32'h1, 32'h0));
        directed.push_back(make_cmd(OP_PUSH_FRONT, 32'h7fff_ffff, 32'h0));
        directed.push_back(make_cmd(OP_PUSH_BACK, 32'h8000_0000, 32'hffff_ffff));
        directed.push_back(make_cmd(OP_PUSH_FRONT, 32'hffff_ffff, 32'h0));
        directed.push_back(make_cmd(OP_PUSH_BACK, 32'h0, 32'h0));
        directed.push_back(make_cmd(OP_INS_AFTER, 32'h5, 32'h8000_0000));
        directed.push_back(make_cmd(OP_INS_AFTER, 32'h7fff_ffff, 32'hffff_ffff));
        directed.push_back(make_cmd(OP_INS_AFTER, 32'h3, 32'h0000_3039));
        directed.push_back(make_cmd(OP_DEL_MATCH, 32'h0, 32'h7fff_ffff));
        directed.push_back(make_cmd(OP_DEL_MATCH, 32'h0, 32'h5555_5555));
        directed.push_back(make_cmd(3'd6, 32'haaaa_aaaa, 32'h5555_5555));
        directed.push_back(make_cmd(3'd7, 32'h5555_5555, 32'haaaa_aaaa));
        directed.push_back(make_cmd(OP_DEL_MATCH, 32'h0, 32'h5));
        directed.push_back(make_cmd(OP_INS_AFTER, 32'h8000_0000, 32'h0));
        directed.push_back(make_cmd(OP_POP_FRONT, 32'h0, 32'h0));
        directed.push_back(make_cmd(OP_POP_BACK, 32'h0, 32'h0));
        directed.push_back(make_cmd(OP_DEL_MATCH, 32'h0, 32'h7fff_ffff));
        directed.push_back(make_cmd(OP_POP_BACK, 32'h0, 32'h0));
        directed.push_back(make_cmd(OP_POP_FRONT, 32'h0, 32'h0));
        directed.push_back(make_cmd(OP_POP_FRONT, 32'h0, 32'h0));
        foreach (directed[i]) send_command(directed[i]);

        while (sent < N_RANDOM) begin
            blk_len = $urandom_range(10, 40);
            grow    = !grow;
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 10;
                default: idle_pct = 30;
            endcase
            if (sent >= N_RANDOM - QUIET_TAIL) no_idle = 1'b1;
            if (!hold_done && sent >= 200) begin
                // long result stall while commands keep coming
                hold_left = HOLD_CYCLES;
                idle_pct  = 0;
                hold_done = 1'b1;
            end
            if (!pause_done && sent >= 450) begin
                // drain everything before continuing
                s_valid <= 1'b0;
                @(negedge aclk);
                while (sb.pending() != 0) @(negedge aclk);
                pause_done = 1'b1;
            end
            repeat (blk_len) begin
                c = random_command(grow);
                if (!no_idle && $urandom_range(0, 99) < idle_pct)
                    sender_gap($urandom_range(1, 14));
                send_command(c);
                if (c.operation <= OP_DEL_MATCH) sent++;
            end
        end

        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);

        $display("run: %0d commands sent, %0d results checked, %0d mismatches",
                 sb.commands, sb.results, sb.errors);
        $display("statuses: done %0d, key not found %0d, list empty %0d, list full %0d",
                 sb.status_seen[ST_DONE], sb.status_seen[ST_NOT_FOUND],
                 sb.status_seen[ST_EMPTY], sb.status_seen[ST_FULL]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ordered_list_engine_top verification clean");
        end else begin
            $display("ordered_list_engine_top verification failed");
        end
        $finish;
    end

endmodule
